>>> design/csp_pkg.sv
// Shared constants, sine table coefficients and saturation helper for the
// CTRV sigma-point predictor. No dependencies.
`default_nettype none

package csp_pkg;

  localparam int STATE_DIM   = 5;
  localparam int FW          = 32;
  localparam int DT_W        = 20;
  localparam int THR_W       = 16;
  localparam int IN_TDATA_W  = 248;
  localparam int OUT_TDATA_W = STATE_DIM * FW;

  localparam logic [THR_W-1:0] THR_RESET = 16'd66;

  // radians (Q32) to 32-bit turn phase
  localparam logic [29:0] TURN_SCALE   = 30'd683565276;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;

  // odd Taylor terms of sin, Q30, Horner order after the t^11 term
  localparam logic [30:0] SC11 = 31'd3864;
  localparam logic [30:0] SIN_COEF [5] = '{31'd172272, 31'd5026995, 31'd85569306,
                                           31'd693598668, 31'd1686629713};

  localparam int SIN_LAT = 7;
  localparam int SIN_W   = 26;

  localparam int QUO_W   = 49;
  localparam int DEN_W   = 32;
  localparam int DIV_LAT = QUO_W;

  localparam int SUM_W = 52;
  localparam int PIPE_LAT = 5 + SIN_LAT + 2 + DIV_LAT + 2;

  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-32){1'b0}}, 32'h7fff_ffff};
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-32){1'b1}}, 32'h8000_0000};

  function automatic logic [FW-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic [FW-1:0] r;
    if (x > SAT_MAX) begin
      r = 32'h7fff_ffff;
    end else if (x < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = x[FW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/csp_sine.sv
// Pipelined Q24 sine of a 32-bit turn phase: fold, square, Horner, round.
// Depends on csp_pkg.
`default_nettype none

module csp_sine (
  input  logic                               clk,
  input  logic                               en,
  input  logic [31:0]                        phase,
  output logic signed [csp_pkg::SIN_W-1:0]   sin_q24
);
  import csp_pkg::*;

  localparam int NH = SIN_LAT - 2;

  logic [30:0] t_r    [SIN_LAT-1];
  logic [30:0] t2_r   [SIN_LAT-1];
  logic [30:0] p_r    [SIN_LAT-1];
  logic [1:0]  quad_r [SIN_LAT-1];

  logic [30:0] t_fold;
  logic [61:0] sq;
  logic [61:0] fp;
  logic [30:0] s_c;
  logic [30:0] s_rnd;
  logic [24:0] mag;

  assign t_fold = phase[30] ? ONE_Q30 - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
  assign sq     = {31'd0, t_fold} * {31'd0, t_fold};

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]    <= t_fold;
      t2_r[0]   <= sq[60:30];
      p_r[0]    <= SC11;
      quad_r[0] <= phase[31:30];
    end
  end

  for (genvar k = 1; k <= NH; k++) begin : g_horner
    logic [61:0] prod;
    assign prod = {31'd0, p_r[k-1]} * {31'd0, t2_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k]    <= SIN_COEF[k-1] - prod[60:30];
        t_r[k]    <= t_r[k-1];
        t2_r[k]   <= t2_r[k-1];
        quad_r[k] <= quad_r[k-1];
      end
    end
  end

  assign fp    = {31'd0, p_r[NH]} * {31'd0, t_r[NH]};
  assign s_c   = (fp[60:30] > ONE_Q30) ? ONE_Q30 : fp[60:30];
  assign s_rnd = s_c + 31'd32;
  assign mag   = s_rnd[30:6];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q24 <= quad_r[NH][1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

>>> design/csp_div.sv
// Restoring unsigned divider, one quotient bit per pipeline stage.
// Depends on csp_pkg.
`default_nettype none

module csp_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [csp_pkg::QUO_W-1:0]   num,
  input  logic [csp_pkg::DEN_W-1:0]   den,
  output logic [csp_pkg::QUO_W-1:0]   quo
);
  import csp_pkg::*;

  logic [DEN_W-1:0] rm [1:DIV_LAT-1];
  logic [DEN_W-1:0] dd [1:DIV_LAT-1];
  logic [QUO_W-1:0] nm [1:DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QUO_W-1:0] n_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign d_in = den;
      assign n_in = num;
    end else begin : g_next
      assign r_in = rm[i];
      assign d_in = dd[i];
      assign n_in = nm[i];
    end

    assign trial = {r_in, n_in[QUO_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        nm[i+1] <= {n_in[QUO_W-2:0], ge};
      end
    end

    if (i < DIV_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rm[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          dd[i+1] <= d_in;
        end
      end
    end
  end

  assign quo = nm[DIV_LAT];

endmodule

`default_nettype wire

>>> design/ctrv_sigma_point_predict.sv
// CTRV sigma-point predictor, top level. Depends on csp_pkg, csp_sine, csp_div.
// The datapath has 65 register stages from input transaction to output valid.
// Throughput: one transaction per cycle; the depth is set mostly by the
// 49-stage arc-motion divider. The pipeline holds while the output stalls.
// Reset (rst, synchronous) clears all valid bits and sets the threshold to 66.
`default_nettype none

module ctrv_sigma_point_predict (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, speed, heading, turn_rate, accel_noise, turn_accel_noise,
  // time_step, zero pad
  input  logic [csp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pred_pos_x, pred_pos_y, pred_speed, pred_heading, pred_turn_rate
  output logic [csp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csp_pkg::THR_W-1:0]         cfg_data
);
  import csp_pkg::*;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] v;
    logic signed [36:0] t;
    logic signed [39:0] acc;
    logic [31:0]        mag;
    logic               yneg;
    logic               arc;
    logic [31:0]        speed;
    logic [31:0]        heading;
    logic [31:0]        turn;
    logic               done;
  } mid_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] base_x;
    logic signed [SUM_W-1:0] base_y;
    logic signed [SUM_W-1:0] strt_x;
    logic signed [SUM_W-1:0] strt_y;
    logic                    neg_x;
    logic                    neg_y;
    logic                    arc;
    logic [31:0]             speed;
    logic [31:0]             heading;
    logic [31:0]             turn;
    logic                    done;
  } tail_t;

  logic                en;
  logic [PIPE_LAT-1:0] vld;
  logic [THR_W-1:0]    thr;

  assign en            = !vld[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[PIPE_LAT-1];
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      thr <= THR_RESET;
    end else begin
      if (en) begin
        vld <= {vld[PIPE_LAT-2:0], s_axis_tvalid};
      end
      if (cfg_valid) begin
        thr <= cfg_data;
      end
    end
  end

  // stage 0: input register
  logic signed [31:0] px0, py0, v0, yaw0, yawd0, na0, nyy0;
  logic [DT_W-1:0]    dt0;
  logic               done0;

  always_ff @(posedge clk) begin
    if (en) begin
      px0   <= s_axis_tdata[31:0];
      py0   <= s_axis_tdata[63:32];
      v0    <= s_axis_tdata[95:64];
      yaw0  <= s_axis_tdata[127:96];
      yawd0 <= s_axis_tdata[159:128];
      na0   <= s_axis_tdata[191:160];
      nyy0  <= s_axis_tdata[223:192];
      dt0   <= s_axis_tdata[243:224];
      done0 <= s_axis_tlast;
    end
  end

  // stage 1: products with dt, yaw phase product, branch select
  logic signed [62:0] yk1;
  logic signed [52:0] ydt1, vdt1, nadt1, nydt1;
  logic [39:0]        dt2_1;
  logic [31:0]        mag0, mag1;
  logic               arc1, done1;
  logic signed [31:0] px1, py1, v1, yaw1, yawd1, na1, nyy1;

  assign mag0 = yawd0[31] ? 32'd0 - $unsigned(yawd0) : $unsigned(yawd0);

  always_ff @(posedge clk) begin
    if (en) begin
      yk1   <= yaw0 * $signed({1'b0, TURN_SCALE});
      ydt1  <= yawd0 * $signed({1'b0, dt0});
      vdt1  <= v0 * $signed({1'b0, dt0});
      nadt1 <= na0 * $signed({1'b0, dt0});
      nydt1 <= nyy0 * $signed({1'b0, dt0});
      dt2_1 <= {20'd0, dt0} * {20'd0, dt0};
      mag1  <= mag0;
      arc1  <= mag0 > {16'd0, thr};
      px1   <= px0;
      py1   <= py0;
      v1    <= v0;
      yaw1  <= yaw0;
      yawd1 <= yawd0;
      na1   <= na0;
      nyy1  <= nyy0;
      done1 <= done0;
    end
  end

  // stage 2: end angle, half dt squared products, speed and yaw rate
  logic [31:0]             ph0_2;
  logic signed [53:0]      a1_2;
  logic signed [55:0]      hna2, hny2;
  logic signed [SUM_W-1:0] hp2;
  logic signed [36:0]      t2;
  logic [31:0]             speed2, turn2, mag2;
  logic signed [31:0]      px2, py2, v2;
  logic                    yneg2, arc2, done2;

  always_ff @(posedge clk) begin
    if (en) begin
      ph0_2  <= yk1[47:16];
      a1_2   <= {{6{yaw1[31]}}, yaw1, 16'd0} + {ydt1[52], ydt1};
      hna2   <= $signed({1'b0, dt2_1[39:17]}) * na1;
      hny2   <= $signed({1'b0, dt2_1[39:17]}) * nyy1;
      hp2    <= SUM_W'(yaw1) + SUM_W'(ydt1 >>> 16);
      t2     <= 37'(vdt1 >>> 16);
      speed2 <= sat32(SUM_W'(v1) + SUM_W'(nadt1 >>> 16));
      turn2  <= sat32(SUM_W'(yawd1) + SUM_W'(nydt1 >>> 16));
      mag2   <= mag1;
      px2    <= px1;
      py2    <= py1;
      v2     <= v1;
      yneg2  <= yawd1[31];
      arc2   <= arc1;
      done2  <= done1;
    end
  end

  // stage 3: end phase partial products, heading
  logic signed [29:0]  ah;
  logic signed [60:0]  phh3;
  logic [53:0]         phl3;
  logic [31:0]         ph0_3, heading3, speed3, turn3, mag3;
  logic signed [39:0]  acc3;
  logic signed [36:0]  t3;
  logic signed [31:0]  px3, py3, v3;
  logic                yneg3, arc3, done3;

  assign ah = 30'(a1_2 >>> 24);

  always_ff @(posedge clk) begin
    if (en) begin
      phh3     <= ah * $signed({1'b0, TURN_SCALE});
      phl3     <= {30'd0, a1_2[23:0]} * {24'd0, TURN_SCALE};
      ph0_3    <= ph0_2;
      heading3 <= sat32(hp2 + SUM_W'(hny2 >>> 16));
      acc3     <= 40'(hna2 >>> 16);
      t3       <= t2;
      speed3   <= speed2;
      turn3    <= turn2;
      mag3     <= mag2;
      px3      <= px2;
      py3      <= py2;
      v3       <= v2;
      yneg3    <= yneg2;
      arc3     <= arc2;
      done3    <= done2;
    end
  end

  // stage 4: end phase
  logic [63:0] phs;
  logic [31:0] ph0_4, ph1_4;
  mid_t        mid4;
  mid_t        mid_d [SIN_LAT];

  assign phs = {phh3[39:0], 24'd0} + {10'd0, phl3};

  always_ff @(posedge clk) begin
    if (en) begin
      ph0_4        <= ph0_3;
      ph1_4        <= phs[63:32];
      mid4.px      <= px3;
      mid4.py      <= py3;
      mid4.v       <= v3;
      mid4.t       <= t3;
      mid4.acc     <= acc3;
      mid4.mag     <= mag3;
      mid4.yneg    <= yneg3;
      mid4.arc     <= arc3;
      mid4.speed   <= speed3;
      mid4.heading <= heading3;
      mid4.turn    <= turn3;
      mid4.done    <= done3;
    end
  end

  // trig pipelines
  logic signed [SIN_W-1:0] s0, c0, s1, c1;

  csp_sine u_s0 (.clk(clk), .en(en), .phase(ph0_4),                .sin_q24(s0));
  csp_sine u_c0 (.clk(clk), .en(en), .phase(ph0_4 + QUARTER_TURN), .sin_q24(c0));
  csp_sine u_s1 (.clk(clk), .en(en), .phase(ph1_4),                .sin_q24(s1));
  csp_sine u_c1 (.clk(clk), .en(en), .phase(ph1_4 + QUARTER_TURN), .sin_q24(c1));

  always_ff @(posedge clk) begin
    if (en) begin
      mid_d[0] <= mid4;
      for (int k = 1; k < SIN_LAT; k++) begin
        mid_d[k] <= mid_d[k-1];
      end
    end
  end

  // stage 12: displacement products
  mid_t               m11;
  logic signed [26:0] ds, dc;
  logic signed [58:0] vds12, vdc12;
  logic signed [62:0] tc12, ts12;
  logic signed [65:0] ac12, as12;
  mid_t               m12;

  assign m11 = mid_d[SIN_LAT-1];
  assign ds  = 27'(s1) - 27'(s0);
  assign dc  = 27'(c0) - 27'(c1);

  always_ff @(posedge clk) begin
    if (en) begin
      vds12 <= m11.v * ds;
      vdc12 <= m11.v * dc;
      tc12  <= m11.t * c0;
      ts12  <= m11.t * s0;
      ac12  <= m11.acc * c0;
      as12  <= m11.acc * s0;
      m12   <= m11;
    end
  end

  // stage 13: divider operands, noise-adjusted bases
  logic [58:0]       vabs_x, vabs_y;
  logic [QUO_W-1:0]  num_x13, num_y13;
  logic [DEN_W-1:0]  den13;
  tail_t             tail13;
  tail_t             tail_d [DIV_LAT];

  assign vabs_x = vds12[58] ? 59'd0 - $unsigned(vds12) : $unsigned(vds12);
  assign vabs_y = vdc12[58] ? 59'd0 - $unsigned(vdc12) : $unsigned(vdc12);

  always_ff @(posedge clk) begin
    if (en) begin
      num_x13        <= vabs_x[56:8];
      num_y13        <= vabs_y[56:8];
      den13          <= m12.mag;
      tail13.base_x  <= SUM_W'(m12.px) + SUM_W'(ac12 >>> 24);
      tail13.base_y  <= SUM_W'(m12.py) + SUM_W'(as12 >>> 24);
      tail13.strt_x  <= SUM_W'(tc12 >>> 24);
      tail13.strt_y  <= SUM_W'(ts12 >>> 24);
      tail13.neg_x   <= vds12[58] ^ m12.yneg;
      tail13.neg_y   <= vdc12[58] ^ m12.yneg;
      tail13.arc     <= m12.arc;
      tail13.speed   <= m12.speed;
      tail13.heading <= m12.heading;
      tail13.turn    <= m12.turn;
      tail13.done    <= m12.done;
    end
  end

  logic [QUO_W-1:0] quo_x, quo_y;

  csp_div u_div_x (.clk(clk), .en(en), .num(num_x13), .den(den13), .quo(quo_x));
  csp_div u_div_y (.clk(clk), .en(en), .num(num_y13), .den(den13), .quo(quo_y));

  always_ff @(posedge clk) begin
    if (en) begin
      tail_d[0] <= tail13;
      for (int k = 1; k < DIV_LAT; k++) begin
        tail_d[k] <= tail_d[k-1];
      end
    end
  end

  // branch select
  tail_t                   tl;
  logic signed [SUM_W-1:0] qx, qy;
  logic signed [SUM_W-1:0] dx63, dy63;
  tail_t                   t63;

  assign tl = tail_d[DIV_LAT-1];
  assign qx = SUM_W'({1'b0, quo_x});
  assign qy = SUM_W'({1'b0, quo_y});

  always_ff @(posedge clk) begin
    if (en) begin
      dx63 <= tl.arc ? (tl.neg_x ? -qx : qx) : tl.strt_x;
      dy63 <= tl.arc ? (tl.neg_y ? -qy : qy) : tl.strt_y;
      t63  <= tl;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {t63.turn, t63.heading, t63.speed,
                       sat32(t63.base_y + dy63), sat32(t63.base_x + dx63)};
      m_axis_tlast <= t63.done;
    end
  end

endmodule

`default_nettype wire

>>> design/csp_checker.sv
// Port-level checks for the CTRV sigma-point predictor, bound to the top.
// Depends on ctrv_sigma_point_predict and csp_pkg.
`default_nettype none

module csp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [csp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input not ready while pipeline can advance");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline is stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind ctrv_sigma_point_predict csp_checker u_csp_checker (.*);

`default_nettype wire

>>> tb/ctrv_sigma_point_predict_checker.sv
// Checker for ctrv_sigma_point_predict: watches the input, output and
// threshold channels, predicts each propagated sigma point and compares.
// Depends on csp_pkg.
module ctrv_sigma_point_predict_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [csp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [csp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [csp_pkg::THR_W-1:0]         cfg_data,
  output int                                errors,
  output int                                pending,
  output int                                results_seen,
  output int                                arc_points
);

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] speed;
    logic [31:0] heading;
    logic [31:0] turn_rate;
    logic        set_done;
  } pred_t;

  pred_t              predicted_q[$];
  logic [15:0]        yaw_thr;

  function automatic logic [31:0] turn_phase(input longint angle);
    longint unsigned u;
    longint unsigned pr;
    u = angle;
    pr = u * longint'(csp_pkg::TURN_SCALE);
    return pr[63:32];
  endfunction

  function automatic longint sine_q24(input logic [31:0] ph);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned p;
    longint unsigned s;
    t = ph[29:0];
    if (ph[30]) begin
      t = 64'h4000_0000 - t;
    end
    t2 = (t * t) >> 30;
    p = csp_pkg::SC11;
    for (int k = 0; k < 5; k++) begin
      p = longint'(csp_pkg::SIN_COEF[k]) - ((p * t2) >> 30);
    end
    s = (p * t) >> 30;
    if (s > 64'h4000_0000) begin
      s = 64'h4000_0000;
    end
    s = (s + 32) >> 6;
    return ph[31] ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [31:0] clip32(input longint x);
    if (x > 64'sh7fff_ffff) begin
      return 32'h7fff_ffff;
    end else if (x < -64'sh8000_0000) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic pred_t propagate(input logic [csp_pkg::IN_TDATA_W-1:0] d,
                                      input logic last, input logic [15:0] thr,
                                      output logic arc);
    longint px, py, v, yaw, yawd, na, nyy, dt;
    longint a0, s0, c0, s1, c1, dx, dy, hd, acc, mag, tt;
    logic [31:0] ph0, ph1;
    pred_t r;
    px = $signed(d[31:0]);
    py = $signed(d[63:32]);
    v = $signed(d[95:64]);
    yaw = $signed(d[127:96]);
    yawd = $signed(d[159:128]);
    na = $signed(d[191:160]);
    nyy = $signed(d[223:192]);
    dt = d[243:224];
    a0 = yaw * 65536;
    ph0 = turn_phase(a0);
    s0 = sine_q24(ph0);
    c0 = sine_q24(ph0 + csp_pkg::QUARTER_TURN);
    mag = yawd < 0 ? -yawd : yawd;
    arc = mag > longint'(thr);
    if (arc) begin
      ph1 = turn_phase(a0 + yawd * dt);
      s1 = sine_q24(ph1);
      c1 = sine_q24(ph1 + csp_pkg::QUARTER_TURN);
      dx = (v * (s1 - s0)) / (yawd * 256);
      dy = (v * (c0 - c1)) / (yawd * 256);
    end else begin
      tt = (v * dt) >>> 16;
      dx = (tt * c0) >>> 24;
      dy = (tt * s0) >>> 24;
    end
    hd = (dt * dt) >> 17;
    acc = (hd * na) >>> 16;
    dx += (acc * c0) >>> 24;
    dy += (acc * s0) >>> 24;
    r.pos_x = clip32(px + dx);
    r.pos_y = clip32(py + dy);
    r.speed = clip32(v + ((na * dt) >>> 16));
    r.heading = clip32(yaw + ((yawd * dt) >>> 16) + ((hd * nyy) >>> 16));
    r.turn_rate = clip32(yawd + ((nyy * dt) >>> 16));
    r.set_done = last;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  always @(posedge clk) begin
    pred_t e;
    logic arc;
    if (rst) begin
      yaw_thr <= csp_pkg::THR_RESET;
      errors = 0;
      results_seen <= 0;
      arc_points <= 0;
      predicted_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        yaw_thr <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_q.push_back(propagate(s_axis_tdata, s_axis_tlast, yaw_thr, arc));
        if (arc) begin
          arc_points <= arc_points + 1;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_q.size() == 0) begin
          $display("unexpected result transaction %h", m_axis_tdata);
          errors++;
        end else begin
          e = predicted_q.pop_front();
          if (m_axis_tdata[31:0] !== e.pos_x) report("pred_pos_x", m_axis_tdata[31:0], e.pos_x);
          if (m_axis_tdata[63:32] !== e.pos_y) report("pred_pos_y", m_axis_tdata[63:32], e.pos_y);
          if (m_axis_tdata[95:64] !== e.speed) report("pred_speed", m_axis_tdata[95:64], e.speed);
          if (m_axis_tdata[127:96] !== e.heading)
            report("pred_heading", m_axis_tdata[127:96], e.heading);
          if (m_axis_tdata[159:128] !== e.turn_rate)
            report("pred_turn_rate", m_axis_tdata[159:128], e.turn_rate);
          if (m_axis_tlast !== e.set_done)
            report("set_done", {31'd0, m_axis_tlast}, {31'd0, e.set_done});
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  assign pending = predicted_q.size();

endmodule

>>> tb/ctrv_sigma_point_predict_tb.sv
// Testbench top for ctrv_sigma_point_predict: directed and random sigma points
// under several thresholds with random stalls. Depends on csp_pkg and the checker.
module ctrv_sigma_point_predict_tb;

  localparam int LIMIT = 300000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // pos_x, pos_y, speed, heading, turn_rate, accel_noise, turn_accel_noise,
  // time_step, zero pad
  logic [csp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // pred_pos_x, pred_pos_y, pred_speed, pred_heading, pred_turn_rate
  logic [csp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [csp_pkg::THR_W-1:0]       cfg_data = '0;
  int                              errors, pending, results_seen, arc_points;
  int                              cycles = 0;
  bit                              calm = 1'b0;
  int                              sent = 0;

  always #2 clk = ~clk;

  ctrv_sigma_point_predict u_top (.*);

  ctrv_sigma_point_predict_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // output stalls in bursts
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_point(input logic [31:0] px, py, v, yaw, yawd, na, nyy,
                            input logic [19:0] dt, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, dt, nyy, na, yawd, yaw, v, py, px};
    s_axis_tlast <= last;
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (csp_pkg::PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] thr);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] span(input int lim);
    return $signed($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic random_point(input logic [15:0] thr);
    logic [31:0] yawd;
    if ($urandom_range(0, 4) == 0) begin
      send_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 20'($urandom), 1'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: yawd = 32'(int'(thr)) + span(2);
        1: yawd = -(32'(int'(thr)) + span(2));
        2: yawd = span(1 << 16);
        default: yawd = span(3 << 16);
      endcase
      send_point(span(1 << 24), span(1 << 24), span(40 << 16), span(7 << 16), yawd,
                 span(5 << 16), span(3 << 16), 20'($urandom_range(0, 1 << 16)),
                 $urandom_range(0, 11) == 0);
    end
  endtask

  initial begin
    logic [15:0] thr_list [4];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset threshold 66
    send_point(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h000a_0000, 32'h0000_8000, 0,
               32'h0001_0000, 32'h0000_4000, 20'h0_8000, 1);
    send_point(0, 0, 32'h0005_0000, 32'h0001_0000, 66, 0, 0, 20'h1_0000, 0);
    send_point(0, 0, 32'h0005_0000, 32'h0001_0000, 67, 0, 0, 20'h1_0000, 0);
    send_point(0, 0, 32'h0005_0000, 32'hffff_0000, -67, 0, 0, 20'h1_0000, 0);
    send_point(0, 0, 32'h0005_0000, 32'h0002_0000, -66, 0, 0, 20'h1_0000, 1);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 20'hf_ffff, 1);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'hf_ffff, 0);
    send_point(32'h7fff_0000, 32'h8001_0000, 32'h7fff_ffff, 32'h0001_9220, 0,
               32'h8000_0000, 32'h7fff_ffff, 20'hf_ffff, 0);
    send_point(0, 0, 32'h0014_0000, 32'h0003_243f, 32'h0001_0000, 0, 0, 20'h0_4000, 0);
    send_point(0, 0, 32'hffec_0000, 32'hfffc_0000, 32'hfffe_0000, 32'hffff_0000,
               32'hffff_8000, 20'h0_0001, 1);
    write_threshold(16'd0);
    send_point(0, 0, 32'h0003_0000, 32'h0000_1000, 1, 0, 0, 20'h0_8000, 0);
    send_point(0, 0, 32'h0003_0000, 32'h0000_1000, -1, 0, 0, 20'h0_8000, 1);
    send_point(0, 0, 32'h0003_0000, 32'h0000_1000, 0, 32'h0001_0000, 0, 20'h0_8000, 0);
    write_threshold(16'hffff);
    send_point(0, 0, 32'h0003_0000, 0, 32'h0000_ffff, 0, 0, 20'h1_0000, 0);
    send_point(0, 0, 32'h0003_0000, 0, 32'h0001_0000, 0, 0, 20'h1_0000, 1);

    thr_list = '{16'd66, 16'd0, 16'hffff, 16'($urandom_range(1, 65534))};
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr_list[ph]);
      for (int i = 0; i < 100; i++) begin
        if (ph == 3 && i >= 60) calm = 1'b1;
        random_point(thr_list[ph]);
      end
    end

    wait_drained();
    $display("%0d sigma points sent, %0d results checked, %0d on the arc branch,",
             sent, results_seen, arc_points);
    $display("thresholds 66, 0, 65535 and %0d, random stalls on both sides", thr_list[3]);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
